// File: rtl/eapg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eapg_pkg
// Types and constants of the ellipse arc point generator.
// ----------------------------------------------------------------------------
package eapg_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int TW           = 35;   // width of angle and trig datapath

    localparam logic signed [TW-1:0] CORDIC_GAIN = 35'sd652032874;
    localparam logic signed [TW-1:0] PI_Q30      = 35'sd3373259425;
    localparam logic signed [TW-1:0] TWO_PI_Q30  = 35'sd6746518851;
    localparam logic signed [TW-1:0] HALF_PI_Q30 = 35'sd1686629713;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_DIVIDE,
        SEQ_ISSUE
    } seq_state_t;

    typedef struct packed {
        logic                 last;
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
        logic signed [31:0]   cx;
        logic signed [31:0]   cy;
        logic [30:0]          rx;
        logic [30:0]          ry;
        logic signed [TW-1:0] x;
        logic signed [TW-1:0] y;
        logic signed [TW-1:0] z;
        logic                 flip;
        logic signed [66:0]   px;
        logic signed [66:0]   py;
    } stage_t;

    function automatic logic signed [TW-1:0] atan_q30(input int idx);
        logic signed [TW-1:0] v;
        unique case (idx)
            0:  v = 35'sd843314856;
            1:  v = 35'sd497837829;
            2:  v = 35'sd263043836;
            3:  v = 35'sd133525158;
            4:  v = 35'sd67021686;
            5:  v = 35'sd33543515;
            6:  v = 35'sd16775850;
            7:  v = 35'sd8388437;
            8:  v = 35'sd4194282;
            9:  v = 35'sd2097149;
            10: v = 35'sd1048575;
            11: v = 35'sd524287;
            12: v = 35'sd262143;
            13: v = 35'sd131071;
            14: v = 35'sd65535;
            15: v = 35'sd32767;
            16: v = 35'sd16383;
            17: v = 35'sd8191;
            18: v = 35'sd4095;
            19: v = 35'sd2047;
            20: v = 35'sd1023;
            21: v = 35'sd511;
            22: v = 35'sd255;
            23: v = 35'sd127;
            24: v = 35'sd63;
            25: v = 35'sd31;
            26: v = 35'sd15;
            27: v = 35'sd7;
            28: v = 35'sd3;
            29: v = 35'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // center plus rounded product, clamped to the coordinate range
    function automatic logic signed [31:0] round_sat(input logic signed [31:0] c,
                                                     input logic signed [66:0] p);
        logic signed [67:0] rnd;
        logic signed [37:0] sum;
        rnd = 68'(p) + 68'sd536870912;
        sum = 38'(rnd >>> 30) + 38'(c);
        if (sum > 38'sd2147483647)
            return 32'sh7fffffff;
        else if (sum < -38'sd2147483648)
            return 32'sh80000000;
        else
            return sum[31:0];
    endfunction

endpackage

// File: rtl/eapg_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eapg_req_if
// Arc request channel: valid/ready handshake with the arc description.
// ----------------------------------------------------------------------------
interface eapg_req_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]        radius_x;
    logic [30:0]        radius_y;
    logic signed [19:0] start_angle;
    logic signed [19:0] end_angle;
    logic [6:0]         segment_count;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;

    modport source (output valid, center_x, center_y, radius_x, radius_y, start_angle,
                    end_angle, segment_count, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, center_x, center_y, radius_x, radius_y, start_angle,
                    end_angle, segment_count, red_in, green_in, blue_in, output ready);
endinterface

// File: rtl/eapg_pt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eapg_pt_if
// Vertex channel: valid/ready handshake with one arc vertex.
// ----------------------------------------------------------------------------
interface eapg_pt_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
    logic               last_point;

    modport source (output valid, point_x, point_y, red_out, green_out, blue_out,
                    last_point, input ready);
    modport sink   (input valid, point_x, point_y, red_out, green_out, blue_out,
                    last_point, output ready);
endinterface

// File: rtl/ellipse_arc_point_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipse_arc_point_generator
// Tessellates an elliptic arc into vertices with a pipelined CORDIC.
// ----------------------------------------------------------------------------
// req takes one arc request (center, radii, start/end angle, vertex count,
// color). pt delivers the vertices in order, the final one with last_point.
// A request with count 0 or end before start yields no vertex.
// After a request is taken the angle step is found by a bit-serial divider
// (no divide for a single vertex). The sequencer then issues one vertex per
// cycle while pt is not stalled into a 35-stage pipeline: two stages of range
// reduction, 30 CORDIC stages, sign fix, multiply, round and saturate.
// req is ready again once the last vertex is issued, while earlier vertices
// still drain.
// A stall on pt freezes the whole pipeline and vertex issue; nothing is
// lost or repeated. Reset empties the pipeline and returns to idle.
// ----------------------------------------------------------------------------
module ellipse_arc_point_generator #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    eapg_req_if.sink    req,
    eapg_pt_if.source   pt
);

    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int DW = 20;                           // width of end - start
    localparam int KW = $clog2(DW + 1);
    localparam int NS = eapg_pkg::CORDIC_STEPS + 5;    // pipeline depth
    localparam int TW = eapg_pkg::TW;

    eapg_pkg::seq_state_t state_reg, state_next;

    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        remain_reg;
    logic [DW-1:0]        quot_reg;
    logic [CW:0]          rem_reg;
    logic [KW-1:0]        step_reg;
    logic signed [20:0]   acc_reg;
    logic signed [20:0]   inc_reg;
    logic signed [31:0]   cx_reg, cy_reg;
    logic [30:0]          rx_reg, ry_reg;
    logic [7:0]           red_reg, green_reg, blue_reg;

    logic                 accept;
    logic                 advance;
    logic                 issue;
    logic                 div_done;
    logic [CW-1:0]        cnt_clamp;
    logic                 req_empty;
    logic [CW-1:0]        divisor;
    logic [CW:0]          rem_shift;
    logic                 rem_ge;

    logic                   vld_reg [NS];
    eapg_pkg::stage_t       st_reg  [NS];
    eapg_pkg::stage_t       st_next [NS];

    assign advance = !vld_reg[NS-1] || pt.ready;
    assign accept  = req.valid && req.ready;

    assign cnt_clamp = (32'(req.segment_count) > MAX_SEGMENTS) ? CW'(MAX_SEGMENTS)
                                                                : CW'(req.segment_count);
    assign req_empty = (cnt_clamp == '0) || (req.end_angle < req.start_angle);

    // restoring divider, one quotient bit a cycle
    assign divisor   = cnt_reg - CW'(1);
    assign rem_shift = {rem_reg[CW-1:0], quot_reg[DW-1]};
    assign rem_ge    = rem_shift >= {1'b0, divisor};
    assign div_done  = step_reg == KW'(DW - 1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            eapg_pkg::SEQ_IDLE:
            begin
                if (req.valid && !req_empty)
                    state_next = (cnt_clamp == CW'(1)) ? eapg_pkg::SEQ_ISSUE
                                                       : eapg_pkg::SEQ_DIVIDE;
            end
            eapg_pkg::SEQ_DIVIDE:
            begin
                if (div_done)
                    state_next = eapg_pkg::SEQ_ISSUE;
            end
            eapg_pkg::SEQ_ISSUE:
            begin
                if (advance && remain_reg == CW'(1))
                    state_next = eapg_pkg::SEQ_IDLE;
            end
            default: state_next = eapg_pkg::SEQ_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        req.ready = 1'b0;
        issue     = 1'b0;
        unique case (state_reg)
            eapg_pkg::SEQ_IDLE:   req.ready = 1'b1;
            eapg_pkg::SEQ_DIVIDE: issue = 1'b0;
            eapg_pkg::SEQ_ISSUE:  issue = advance;
            default:              issue = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= eapg_pkg::SEQ_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cnt_reg    <= cnt_clamp;
            remain_reg <= cnt_clamp;
            quot_reg   <= DW'(21'(req.end_angle) - 21'(req.start_angle));
            rem_reg    <= '0;
            step_reg   <= '0;
            acc_reg    <= 21'(req.start_angle);
            inc_reg    <= '0;
            cx_reg     <= req.center_x;
            cy_reg     <= req.center_y;
            rx_reg     <= req.radius_x;
            ry_reg     <= req.radius_y;
            red_reg    <= req.red_in;
            green_reg  <= req.green_in;
            blue_reg   <= req.blue_in;
        end
        else if (state_reg == eapg_pkg::SEQ_DIVIDE)
        begin
            rem_reg  <= rem_ge ? (rem_shift - {1'b0, divisor}) : rem_shift;
            quot_reg <= {quot_reg[DW-2:0], rem_ge};
            step_reg <= step_reg + KW'(1);
            if (div_done)
                inc_reg <= 21'({1'b0, quot_reg[DW-2:0], rem_ge});
        end
        else if (issue)
        begin
            acc_reg    <= acc_reg + inc_reg;
            remain_reg <= remain_reg - CW'(1);
        end
    end

    // pipeline stage logic
    always_comb
    begin
        st_next[0]       = st_reg[0];
        st_next[0].last  = remain_reg == CW'(1);
        st_next[0].red   = red_reg;
        st_next[0].green = green_reg;
        st_next[0].blue  = blue_reg;
        st_next[0].cx    = cx_reg;
        st_next[0].cy    = cy_reg;
        st_next[0].rx    = rx_reg;
        st_next[0].ry    = ry_reg;
        st_next[0].z     = TW'(acc_reg) <<< 14;
        // first wrap into [-pi, pi]
        if (st_next[0].z > eapg_pkg::PI_Q30)
            st_next[0].z = st_next[0].z - eapg_pkg::TWO_PI_Q30;
        else if (st_next[0].z < -eapg_pkg::PI_Q30)
            st_next[0].z = st_next[0].z + eapg_pkg::TWO_PI_Q30;

        for (int k = 1; k < NS; k++)
        begin
            st_next[k] = st_reg[k-1];
            if (k == 1)
            begin
                // fold into [-pi/2, pi/2], negating both results
                st_next[k].x    = eapg_pkg::CORDIC_GAIN;
                st_next[k].y    = '0;
                st_next[k].flip = 1'b0;
                if (st_reg[k-1].z > eapg_pkg::HALF_PI_Q30)
                begin
                    st_next[k].z    = st_reg[k-1].z - eapg_pkg::PI_Q30;
                    st_next[k].flip = 1'b1;
                end
                else if (st_reg[k-1].z < -eapg_pkg::HALF_PI_Q30)
                begin
                    st_next[k].z    = st_reg[k-1].z + eapg_pkg::PI_Q30;
                    st_next[k].flip = 1'b1;
                end
            end
            else if (k < eapg_pkg::CORDIC_STEPS + 2)
            begin
                if (!st_reg[k-1].z[TW-1])
                begin
                    st_next[k].x = st_reg[k-1].x - (st_reg[k-1].y >>> (k - 2));
                    st_next[k].y = st_reg[k-1].y + (st_reg[k-1].x >>> (k - 2));
                    st_next[k].z = st_reg[k-1].z - eapg_pkg::atan_q30(k - 2);
                end
                else
                begin
                    st_next[k].x = st_reg[k-1].x + (st_reg[k-1].y >>> (k - 2));
                    st_next[k].y = st_reg[k-1].y - (st_reg[k-1].x >>> (k - 2));
                    st_next[k].z = st_reg[k-1].z + eapg_pkg::atan_q30(k - 2);
                end
            end
            else if (k == eapg_pkg::CORDIC_STEPS + 2)
            begin
                if (st_reg[k-1].flip)
                begin
                    st_next[k].x = -st_reg[k-1].x;
                    st_next[k].y = -st_reg[k-1].y;
                end
            end
            else if (k == eapg_pkg::CORDIC_STEPS + 3)
            begin
                st_next[k].px = 67'($signed({1'b0, st_reg[k-1].rx}) * st_reg[k-1].x);
                st_next[k].py = 67'($signed({1'b0, st_reg[k-1].ry}) * st_reg[k-1].y);
            end
            else
            begin
                st_next[k].x = TW'(eapg_pkg::round_sat(st_reg[k-1].cx, st_reg[k-1].px));
                st_next[k].y = TW'(eapg_pkg::round_sat(st_reg[k-1].cy, st_reg[k-1].py));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg[0] <= issue;
            for (int k = 1; k < NS; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < NS; k++)
                st_reg[k] <= st_next[k];
        end
    end

    assign pt.valid      = vld_reg[NS-1];
    assign pt.point_x    = st_reg[NS-1].x[31:0];
    assign pt.point_y    = st_reg[NS-1].y[31:0];
    assign pt.red_out    = st_reg[NS-1].red;
    assign pt.green_out  = st_reg[NS-1].green;
    assign pt.blue_out   = st_reg[NS-1].blue;
    assign pt.last_point = st_reg[NS-1].last;

endmodule

// File: tb/arc_vertex_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_vertex_checker
// Watches the arc request and vertex channels, works out the vertices that
// each accepted request must produce and compares them in order.
// ----------------------------------------------------------------------------
module arc_vertex_checker (
    input  logic  clk,
    input  logic  rst_n,
    eapg_req_if   req,
    eapg_pt_if    pt,
    output int    fail_count,
    output int    pending
);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic               last;
    } vertex_t;

    localparam int MAX_VERTS = 64;

    vertex_t      vertex_q[$];
    logic signed [23:0] angle_acc;
    logic [6:0]   vtx_idx;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    task automatic sin_cos(input longint ang, output longint c, output longint s);
        longint x, y, z, dx, dy;
        bit flip;
        x = eapg_pkg::CORDIC_GAIN;
        y = 0;
        flip = 0;
        while (ang > longint'(eapg_pkg::PI_Q30)) ang -= longint'(eapg_pkg::TWO_PI_Q30);
        while (ang < -longint'(eapg_pkg::PI_Q30)) ang += longint'(eapg_pkg::TWO_PI_Q30);
        // fold into the right half plane, which negates both outputs
        if (ang > longint'(eapg_pkg::HALF_PI_Q30))
        begin
            ang -= longint'(eapg_pkg::PI_Q30);
            flip = 1;
        end
        else if (ang < -longint'(eapg_pkg::HALF_PI_Q30))
        begin
            ang += longint'(eapg_pkg::PI_Q30);
            flip = 1;
        end
        z = ang;
        for (int i = 0; i < eapg_pkg::CORDIC_STEPS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(eapg_pkg::atan_q30(i));
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(eapg_pkg::atan_q30(i));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic logic signed [31:0] place_coord(longint ctr, longint rad, longint t);
        longint v;
        v = ctr + floor_shift(rad * t + (64'sd1 <<< 29), 30);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    task automatic tessellate_arc();
        longint sa, ea, inc, c, s;
        int     cnt;
        vertex_t v;
        sa  = req.start_angle;
        ea  = req.end_angle;
        cnt = req.segment_count;
        inc = 0;
        if (cnt > MAX_VERTS) cnt = MAX_VERTS;
        if (cnt == 0 || ea < sa) return;
        if (cnt > 1) inc = (ea - sa) / (cnt - 1);
        angle_acc = 24'(sa);
        for (int k = 0; k < cnt; k++)
        begin
            vtx_idx = 7'(k);
            sin_cos(longint'(angle_acc) * 16384, c, s);
            v.x     = place_coord(req.center_x, longint'(req.radius_x), c);
            v.y     = place_coord(req.center_y, longint'(req.radius_y), s);
            v.red   = req.red_in;
            v.green = req.green_in;
            v.blue  = req.blue_in;
            v.last  = (int'(vtx_idx) + 1 == cnt);
            vertex_q = {vertex_q, v};
            angle_acc = 24'(longint'(angle_acc) + inc);
        end
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
        angle_acc  = '0;
        vtx_idx    = '0;
    end

    always @(posedge clk)
    begin
        vertex_t e;
        if (rst_n)
        begin
            if (pt.valid && pt.ready)
            begin
                if (vertex_q.size() == 0)
                    report("unexpected vertex x", pt.point_x, 0);
                else
                begin
                    e = vertex_q.pop_front();
                    if (pt.point_x !== e.x) report("point_x", pt.point_x, e.x);
                    if (pt.point_y !== e.y) report("point_y", pt.point_y, e.y);
                    if (pt.red_out !== e.red) report("red_out", pt.red_out, e.red);
                    if (pt.green_out !== e.green) report("green_out", pt.green_out, e.green);
                    if (pt.blue_out !== e.blue) report("blue_out", pt.blue_out, e.blue);
                    if (pt.last_point !== e.last) report("last_point", pt.last_point, e.last);
                end
            end
            if (req.valid && req.ready)
                tessellate_arc();
        end
        pending = vertex_q.size();
    end
endmodule

// File: tb/ellipse_arc_point_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipse_arc_point_generator_tb
// Drives directed and random arc requests with random gaps and output
// stalls; the checker predicts every vertex and counts mismatches.
// ----------------------------------------------------------------------------
module ellipse_arc_point_generator_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int NUM_RANDOM     = 350;
    localparam int PI_Q16         = 205887;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    int   stall_left;
    bit   stall_mode;

    eapg_req_if req ();
    eapg_pt_if  pt ();

    ellipse_arc_point_generator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .pt    (pt.source)
    );

    arc_vertex_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .pt         (pt),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #1 clk = ~clk;

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(0, 2);
    endfunction

    // sink side: random stalls, a few long ones, with long phases of none
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= ~stall_mode;
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            pt.ready   <= 1'b0;
        end
        else if (stall_mode)
            pt.ready <= 1'b1;
        else if ($urandom_range(0, 49) == 0)
        begin
            stall_left <= $urandom_range(10, 60);
            pt.ready   <= 1'b0;
        end
        else if ($urandom_range(0, 19) == 0)
            pt.ready <= 1'b0;
        else
            pt.ready <= ($urandom_range(0, 3) != 0);
    end

    // watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (pt.valid && pt.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // valid stays high into the next request when there is no gap
    task automatic send_arc(input logic signed [31:0] cx, input logic signed [31:0] cy,
                            input logic [30:0] rx, input logic [30:0] ry,
                            input logic signed [19:0] sa, input logic signed [19:0] ea,
                            input logic [6:0] cnt);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req.valid         <= 1'b1;
        req.center_x      <= cx;
        req.center_y      <= cy;
        req.radius_x      <= rx;
        req.radius_y      <= ry;
        req.start_angle   <= sa;
        req.end_angle     <= ea;
        req.segment_count <= cnt;
        req.red_in        <= 8'($urandom);
        req.green_in      <= 8'($urandom);
        req.blue_in       <= 8'($urandom);
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    function automatic logic [30:0] rand_radius();
        unique case ($urandom_range(0, 3))
            0: return 31'($urandom_range(0, 31'h7fff_ffff));
            1: return 31'($urandom_range(0, 32'h00ff_ffff));
            2: return 31'h7fff_ffff;
            default: return 31'($urandom_range(0, 32'h0000_ffff));
        endcase
    endfunction

    function automatic logic [6:0] rand_count();
        unique case ($urandom_range(0, 9))
            0: return 7'($urandom_range(0, 127));
            1: return 7'd64;
            default: return 7'($urandom_range(1, 12));
        endcase
    endfunction

    initial
    begin
        logic signed [19:0] a0, a1;
        clk = 0;
        rst_n = 0;
        stall_mode = 0;
        stall_left = 0;
        idle_cycles = 0;
        req.valid = 0;
        req.center_x = 0;
        req.center_y = 0;
        req.radius_x = 0;
        req.radius_y = 0;
        req.start_angle = 0;
        req.end_angle = 0;
        req.segment_count = 0;
        req.red_in = 0;
        req.green_in = 0;
        req.blue_in = 0;
        pt.ready = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full circle
        send_arc(0, 0, 31'd655360, 31'd655360, 20'sd0, 20'(2 * PI_Q16), 7'd16);
        // single vertex
        send_arc(32'sd1000, -32'sd1000, 31'd65536, 31'd131072, 20'sd1234, 20'sd1234, 7'd1);
        // end before start
        send_arc(0, 0, 31'd65536, 31'd65536, 20'sd100, 20'sd99, 7'd8);
        // zero count
        send_arc(0, 0, 31'd65536, 31'd65536, 20'sd0, 20'sd1000, 7'd0);
        // count above the maximum
        send_arc(0, 0, 31'd65536, 31'd65536, 20'sd0, 20'sd70000, 7'd127);
        send_arc(0, 0, 31'd65536, 31'd65536, -20'sd70000, 20'sd70000, 7'd65);
        // saturation in both directions, full angle span
        send_arc(32'sh7fff_ffff, 32'sh8000_0000, 31'h7fff_ffff, 31'h7fff_ffff,
                 20'sh80000, 20'sh7ffff, 7'd64);
        send_arc(32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff,
                 20'sh80000, 20'sh7ffff, 7'd9);
        send_arc(32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff,
                 20'sh7ffff, 20'sh7ffff, 7'd1);
        // even increments, tiny and zero radii, clamped count
        send_arc(0, 0, 31'd1000000, 31'd3, 20'sd0, 20'sd10, 7'd3);
        send_arc(-32'sd5, 32'sd5, 31'd0, 31'd0, -20'sd7, 20'sd7, 7'd2);
        send_arc(32'sh5555_5555, 32'shaaaa_aaaa, 31'h2aaa_aaaa, 31'h5555_5555,
                 20'sh55555, 20'sh7ffff, 7'h7f);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            a0 = 20'($urandom);
            a1 = 20'($urandom);
            if ($urandom_range(0, 9) != 0 && a1 < a0)
            begin
                a0 = a0 ^ a1;
                a1 = a0 ^ a1;
                a0 = a0 ^ a1;
            end
            send_arc($urandom, $urandom, rand_radius(), rand_radius(), a0, a1, rand_count());
        end
        req.valid <= 1'b0;
        @(posedge clk);

        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// File: filelist.f
rtl/eapg_pkg.sv
rtl/eapg_req_if.sv
rtl/eapg_pt_if.sv
rtl/ellipse_arc_point_generator.sv
tb/arc_vertex_checker.sv
tb/ellipse_arc_point_generator_tb.sv
